// ===== design/mfb_pkg.sv =====
// shared types and constants for the monochrome frame buffer / serial lcd refresh block
// no dependencies
package mfb_pkg;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_DOT     = 2'd1;
    localparam logic [1:0] OP_GLYPH   = 2'd2;
    localparam logic [1:0] OP_REFRESH = 2'd3;

    localparam logic [7:0] SYNC_CMD   = 8'hf8;
    localparam logic [7:0] SYNC_DATA  = 8'hfa;
    localparam logic [7:0] ADDR_BASE  = 8'h80;
    localparam logic [3:0] GLYPH_LAST = 4'd12;

    typedef struct packed {
        logic [1:0] opcode;
        logic [6:0] x;
        logic [5:0] y;
        logic       color;
        logic [3:0] char_code;
    } cmd_t;

    // one glyph row, 5 bits, msb is leftmost column (width-5 glyphs)
    function automatic logic [4:0] glyph_row(input logic [3:0] code, input logic [2:0] r);
        logic [7:0] rows [0:4];
        begin
            rows[0] = 8'h00; rows[1] = 8'h00; rows[2] = 8'h00;
            rows[3] = 8'h00; rows[4] = 8'h00;
            case (code)
                4'd0: begin rows[0]=8'h06; rows[1]=8'h09; rows[2]=8'h09; rows[3]=8'h09; rows[4]=8'h06; end
                4'd1: begin rows[0]=8'h02; rows[1]=8'h06; rows[2]=8'h02; rows[3]=8'h02; rows[4]=8'h07; end
                4'd2: begin rows[0]=8'h06; rows[1]=8'h09; rows[2]=8'h02; rows[3]=8'h04; rows[4]=8'h0f; end
                4'd3: begin rows[0]=8'h06; rows[1]=8'h09; rows[2]=8'h02; rows[3]=8'h09; rows[4]=8'h06; end
                4'd4: begin rows[0]=8'h02; rows[1]=8'h06; rows[2]=8'h0a; rows[3]=8'h0f; rows[4]=8'h02; end
                4'd5: begin rows[0]=8'h0e; rows[1]=8'h08; rows[2]=8'h0e; rows[3]=8'h01; rows[4]=8'h0e; end
                4'd6: begin rows[0]=8'h06; rows[1]=8'h08; rows[2]=8'h0e; rows[3]=8'h09; rows[4]=8'h06; end
                4'd7: begin rows[0]=8'h0f; rows[1]=8'h01; rows[2]=8'h02; rows[3]=8'h04; rows[4]=8'h04; end
                4'd8: begin rows[0]=8'h06; rows[1]=8'h09; rows[2]=8'h06; rows[3]=8'h09; rows[4]=8'h06; end
                4'd9: begin rows[0]=8'h06; rows[1]=8'h09; rows[2]=8'h07; rows[3]=8'h01; rows[4]=8'h06; end
                // point and colon are 2 wide: bit 3 maps to the second column
                4'd10: begin rows[4]=8'h08; end
                4'd11: begin rows[1]=8'h08; rows[3]=8'h08; end
                default: ;
            endcase
            glyph_row = (r < 3'd5) ? rows[r][4:0] : 5'd0;
        end
    endfunction

endpackage

// ===== design/mfb_front.sv =====
// front end: takes requests from the start/busy port into a two-entry queue
// depends on mfb_pkg
module mfb_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  mfb_pkg::cmd_t cmd_in,
    output logic          busy,
    output logic          q_valid,
    output mfb_pkg::cmd_t q_cmd,
    input  logic          q_pop
);
    mfb_pkg::cmd_t mem_reg [0:1];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic          push;

    assign busy    = (cnt_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule

// ===== design/mfb_back.sv =====
// back end: frame store memory, clear sweep, dot and glyph writes, refresh walk
// depends on mfb_pkg
module mfb_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  mfb_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          strobe,
    output logic          is_data,
    output logic [7:0]    byte_value,
    output logic [23:0]   serial_frame,
    output logic          last
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CLR   = 7'b0000010,
        S_RD    = 7'b0000100,
        S_WR    = 7'b0001000,
        S_CMD   = 7'b0010000,
        S_DRD   = 7'b0100000,
        S_DOUT  = 7'b1000000
    } state_t;

    state_t        state_reg, state_next;
    logic [15:0]   mem [0:511];
    logic [15:0]   rdata_reg;
    logic [8:0]    cnt_reg;      // clear address, glyph dot index, word index
    logic [2:0]    gi_reg;       // glyph row of the current dot
    logic [2:0]    gj_reg;       // glyph column of the current dot
    mfb_pkg::cmd_t cur_reg;
    logic          out_v_reg, out_d_reg, out_l_reg;
    logic [7:0]    out_b_reg;
    logic          cmd_sel_reg;
    logic          byte_sel_reg;

    // dot address selection
    logic [6:0]  px;
    logic [5:0]  py;
    logic        dot_ok, dot_on;
    logic [7:0]  gx_sum;
    logic [6:0]  gy_sum;
    logic [2:0]  gi;
    logic [2:0]  gj;
    logic [4:0]  grow;
    logic        wide;
    logic [8:0]  dot_addr;
    logic [15:0] dot_mask;
    logic [8:0]  rd_addr;

    always_comb
    begin
        wide   = (cur_reg.char_code < 4'd10) || (cur_reg.char_code == 4'd12);
        gi     = gi_reg;
        gj     = gj_reg;
        grow   = mfb_pkg::glyph_row(cur_reg.char_code, gi);
        gx_sum = {1'b0, cur_reg.x} + (wide ? {5'd0, gj} : {5'd0, gj} + 8'd0);
        gy_sum = {1'b0, cur_reg.y} + {4'd0, gi};
        if (cur_reg.opcode == mfb_pkg::OP_DOT)
        begin
            px     = cur_reg.x;
            py     = cur_reg.y;
            dot_ok = 1'b1;
            dot_on = cur_reg.color;
        end
        else
        begin
            px     = gx_sum[6:0];
            py     = gy_sum[5:0];
            dot_ok = !gx_sum[7] && !gy_sum[6] && (wide || gj < 3'd2)
                     && grow[3'd4 - gj] && (cur_reg.char_code <= mfb_pkg::GLYPH_LAST);
            dot_on = 1'b1;
        end
        dot_addr = {py[4:0], py[5], px[6:4]};
        dot_mask = 16'h8000 >> px[3:0];
    end

    assign rd_addr = (state_reg inside {S_DRD, S_DOUT})
                     ? {cur_reg.y[4:0], cnt_reg[3:0]} : dot_addr;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLR)
        begin
            mem[cnt_reg] <= 16'h0000;
        end
        else if (state_reg == S_WR && dot_ok)
        begin
            mem[dot_addr] <= dot_on ? (rdata_reg | dot_mask) : (rdata_reg & ~dot_mask);
        end
        rdata_reg <= mem[rd_addr];
    end

    logic last_dot;
    assign last_dot = (cur_reg.opcode == mfb_pkg::OP_DOT) || (cnt_reg == 9'd24);

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.opcode)
                        mfb_pkg::OP_CLEAR:   state_next = S_CLR;
                        mfb_pkg::OP_REFRESH: state_next = S_CMD;
                        default:             state_next = S_RD;
                    endcase
                end
            end
            S_CLR:  if (cnt_reg == 9'd511) state_next = S_IDLE;
            S_RD:   state_next = S_WR;
            S_WR:   state_next = last_dot ? S_IDLE : S_RD;
            S_CMD:  if (cmd_sel_reg) state_next = S_DRD;
            S_DRD:  state_next = S_DOUT;
            S_DOUT: if (byte_sel_reg) state_next = (cnt_reg[3:0] == 4'd15) ? S_IDLE : S_DRD;
            default: state_next = S_IDLE;
        endcase
    end

    // clear sweep zeroes all 512 words; glyph takes 25 read-modify-write pairs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            cnt_reg      <= 9'd0;
            gi_reg       <= 3'd0;
            gj_reg       <= 3'd0;
            out_v_reg    <= 1'b0;
            cmd_sel_reg  <= 1'b0;
            byte_sel_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_v_reg <= (state_reg inside {S_CMD, S_DOUT});
            case (state_reg)
                S_IDLE:
                begin
                    cnt_reg      <= 9'd0;
                    gi_reg       <= 3'd0;
                    gj_reg       <= 3'd0;
                    cmd_sel_reg  <= 1'b0;
                    byte_sel_reg <= 1'b0;
                end
                S_CLR:  cnt_reg <= cnt_reg + 9'd1;
                S_WR:
                begin
                    cnt_reg <= cnt_reg + 9'd1;
                    // step through the 5x5 dot grid row by row
                    if (gj_reg == 3'd4)
                    begin
                        gj_reg <= 3'd0;
                        gi_reg <= gi_reg + 3'd1;
                    end
                    else
                    begin
                        gj_reg <= gj_reg + 3'd1;
                    end
                end
                S_CMD:  cmd_sel_reg <= 1'b1;
                S_DOUT:
                begin
                    byte_sel_reg <= ~byte_sel_reg;
                    if (byte_sel_reg) cnt_reg <= cnt_reg + 9'd1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_valid) cur_reg <= q_cmd;
        if (state_reg == S_CMD)
        begin
            out_d_reg <= 1'b0;
            out_l_reg <= 1'b0;
            out_b_reg <= cmd_sel_reg ? mfb_pkg::ADDR_BASE
                                     : (mfb_pkg::ADDR_BASE | {2'b00, cur_reg.y});
        end
        else
        begin
            out_d_reg <= 1'b1;
            out_l_reg <= byte_sel_reg && (cnt_reg[3:0] == 4'd15);
            if (cur_reg.y[5]) out_b_reg <= 8'h00;
            else out_b_reg <= byte_sel_reg ? rdata_reg[7:0] : rdata_reg[15:8];
        end
    end

    assign strobe       = out_v_reg;
    assign is_data      = out_d_reg;
    assign byte_value   = out_b_reg;
    assign last         = out_l_reg;
    assign serial_frame = {(out_d_reg ? mfb_pkg::SYNC_DATA : mfb_pkg::SYNC_CMD),
                           out_b_reg[7:4], 4'h0, out_b_reg[3:0], 4'h0};
endmodule

// ===== design/mono_framebuffer_serial_lcd_refresh.sv =====
// top level of the monochrome frame buffer with serial lcd refresh output
// depends on mfb_pkg, mfb_front, mfb_back
//
// channel   | signals                              | direction
// request   | start, busy, opcode x y color code   | in
// frame     | strobe, is_data byte_value frame last| out
//
// dot: dispatch, read, write; glyph: dispatch, then 25 read/write pairs
// refresh: dispatch, 2 command frames, then per word a read, a high byte and a low byte
// clear: dispatch then one word per cycle; the same sweep runs after reset
// each frame leaves in the cycle after the state that makes it; the receiver cannot stall
// requests queue two deep; busy rises only when the queue is full
module mono_framebuffer_serial_lcd_refresh (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [6:0]  x,
    input  logic [5:0]  y,
    input  logic        color,
    input  logic [3:0]  char_code,
    output logic        strobe,
    output logic        is_data,
    output logic [7:0]  byte_value,
    output logic [23:0] serial_frame,
    output logic        last
);
    mfb_pkg::cmd_t cmd_in, q_cmd;
    logic          q_valid, q_pop;

    assign cmd_in = '{opcode: opcode, x: x, y: y, color: color, char_code: char_code};

    mfb_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd_in(cmd_in), .busy(busy),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
    );

    mfb_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
        .strobe(strobe), .is_data(is_data), .byte_value(byte_value),
        .serial_frame(serial_frame), .last(last)
    );
endmodule

// ===== design/mfb_checker.sv =====
// port-level checks for the frame buffer refresh block
// depends on mono_framebuffer_serial_lcd_refresh ports only
module mfb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        strobe,
    input logic        is_data,
    input logic [7:0]  byte_value,
    input logic [23:0] serial_frame,
    input logic        last
);
    a_sync: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> serial_frame[23:16] == (is_data ? 8'hfa : 8'hf8))
        else $error("sync byte mismatch");
    a_nib: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> serial_frame[15:12] == byte_value[7:4] && serial_frame[7:4] == byte_value[3:0])
        else $error("nibble mismatch");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> is_data && $past(strobe))
        else $error("last on bad frame");
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("frame after last");
endmodule

bind mono_framebuffer_serial_lcd_refresh mfb_checker u_mfb_checker (
    .clk(clk), .rst_n(rst_n), .strobe(strobe), .is_data(is_data),
    .byte_value(byte_value), .serial_frame(serial_frame), .last(last)
);
